@@ rtl/crp_pkg.sv @@
package crp_pkg;

	localparam int REG_COUNT = 128;
	localparam int IDX_W     = 7;
	localparam int S_DATA_W  = 72;
	localparam int M_DATA_W  = 8;

	localparam logic [15:0] PORT_INDEX = 16'h0070;
	localparam logic [15:0] PORT_DATA  = 16'h0071;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [IDX_W-1:0] REG_SEC     = 7'h00;
	localparam logic [IDX_W-1:0] REG_MIN     = 7'h02;
	localparam logic [IDX_W-1:0] REG_HOUR    = 7'h04;
	localparam logic [IDX_W-1:0] REG_WDAY    = 7'h06;
	localparam logic [IDX_W-1:0] REG_DAY     = 7'h07;
	localparam logic [IDX_W-1:0] REG_MONTH   = 7'h08;
	localparam logic [IDX_W-1:0] REG_YEAR    = 7'h09;
	localparam logic [IDX_W-1:0] REG_A       = 7'h0A;
	localparam logic [IDX_W-1:0] REG_B       = 7'h0B;
	localparam logic [IDX_W-1:0] REG_C       = 7'h0C;
	localparam logic [IDX_W-1:0] REG_D       = 7'h0D;
	localparam logic [IDX_W-1:0] REG_F       = 7'h0F;
	localparam logic [IDX_W-1:0] REG_CENTURY = 7'h32;

	localparam logic [7:0] REG_A_RST  = 8'h26;
	localparam logic [7:0] REG_B_RST  = 8'h02;
	localparam logic [7:0] REG_D_VAL  = 8'h80;
	localparam logic [7:0] BYTE_NONE  = 8'hFF;
	localparam int         BIN_BIT    = 2;

	// x / 100 == (x * 5243) >> 19 for x below 43699
	localparam logic [12:0] CENT_RECIP = 13'd5243;
	localparam int          CENT_SHIFT = 19;
	// x / 10 == (x * 205) >> 11 for x below 1029
	localparam logic [7:0]  TEN_RECIP  = 8'd205;
	localparam int          TEN_SHIFT  = 11;

	typedef struct packed {
		logic        req;
		logic [15:0] port;
		logic [7:0]  wdata;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [2:0]  wday;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} item_t;

	typedef struct packed {
		logic       coded;
		logic       bin;
		logic [7:0] value;
	} sel_t;

endpackage

@@ rtl/crp_year.sv @@
module crp_year import crp_pkg::*; (
	input  logic [13:0] year,
	output logic [7:0]  century
);

	logic [26:0] prod;

	assign prod    = 27'(year) * 27'(CENT_RECIP);
	assign century = prod[CENT_SHIFT +: 8];

endmodule

@@ rtl/crp_regs.sv @@
module crp_regs import crp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  logic [7:0] century,
	output logic       is_read,
	output sel_t       sel
);

	logic [IDX_W-1:0] index_q;
	logic [7:0]       reg_a_q;
	logic [7:0]       reg_b_q;
	logic [7:0]       reg_c_q;
	logic [7:0]       reg_f_q;
	logic             in_range;
	logic [13:0]      hundreds;
	logic [6:0]       yr2;

	assign in_range = {1'b0, index_q} < 8'(REG_COUNT);
	assign hundreds = 14'(century) * 14'd100;
	assign yr2      = 7'(item.year - hundreds);
	assign is_read  = (item.req == REQ_READ);

	always_comb begin
		sel.coded = 1'b0;
		sel.bin   = reg_b_q[BIN_BIT];
		sel.value = BYTE_NONE;
		if (item.port == PORT_DATA && in_range) begin
			sel.value = '0;
			unique case (index_q)
				REG_SEC: begin
					sel.coded = 1'b1;
					sel.value = 8'(item.sec);
				end
				REG_MIN: begin
					sel.coded = 1'b1;
					sel.value = 8'(item.min);
				end
				REG_HOUR: begin
					sel.coded = 1'b1;
					sel.value = 8'(item.hour);
				end
				REG_WDAY: begin
					sel.coded = 1'b1;
					sel.value = 8'(item.wday) + 8'd1;
				end
				REG_DAY: begin
					sel.coded = 1'b1;
					sel.value = 8'(item.day);
				end
				REG_MONTH: begin
					sel.coded = 1'b1;
					sel.value = 8'(item.month);
				end
				REG_YEAR: begin
					sel.coded = 1'b1;
					sel.value = 8'(yr2);
				end
				REG_CENTURY: begin
					sel.coded = 1'b1;
					sel.value = century;
				end
				REG_A: sel.value = reg_a_q;
				REG_B: sel.value = reg_b_q;
				REG_C: sel.value = reg_c_q;
				REG_D: sel.value = REG_D_VAL;
				REG_F: sel.value = reg_f_q;
				default: sel.value = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			reg_a_q <= REG_A_RST;
			reg_b_q <= REG_B_RST;
			reg_c_q <= '0;
			reg_f_q <= '0;
		end else if (fire && item.req == REQ_WRITE) begin
			if (item.port == PORT_INDEX) begin
				index_q <= item.wdata[IDX_W-1:0];
			end else if (item.port == PORT_DATA && in_range) begin
				if (index_q == REG_A) reg_a_q <= item.wdata;
				if (index_q == REG_B) reg_b_q <= item.wdata;
				if (index_q == REG_C) reg_c_q <= item.wdata;
				if (index_q == REG_F) reg_f_q <= item.wdata;
			end
		end
	end

endmodule

@@ rtl/crp_coder.sv @@
module crp_coder import crp_pkg::*; (
	input  sel_t       sel,
	output logic [7:0] code
);

	logic [15:0] prod;
	logic [4:0]  tens;
	logic [3:0]  ones;

	assign prod = 16'(sel.value) * 16'(TEN_RECIP);
	assign tens = prod[TEN_SHIFT +: 5];
	assign ones = 4'(sel.value - 8'(tens) * 8'd10);
	assign code = (sel.coded && !sel.bin) ? {tens[3:0], ones} : sel.value;

endmodule

@@ rtl/cmos_rtc_register_port.sv @@
// PC CMOS real-time-clock register window. Each transfer on the slave side is one port
// access; a read produces one byte on the master side, a write produces nothing. Index
// writes go to port 0x70, data accesses to 0x71; only registers 0x0A, 0x0B, 0x0C and
// 0x0F are writable. Data reads return time registers freshly coded from the time fields
// of the same transfer, BCD unless bit 2 of register 0x0B is set. One access is taken
// every cycle; a read passes through the input register, year split, register select and
// coding into the output register before it is presented on the master side, and the
// whole pipeline stalls only while the output register holds a byte not yet taken.
module cmos_rtc_register_port import crp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// port_addr[15:0], write_data[23:16], now_second[29:24], now_minute[35:30],
	// now_hour[40:36], now_weekday[43:41], now_day[48:44], now_month[52:49],
	// now_year[66:53], zero[71:67]
	input  logic [S_DATA_W-1:0] s_tdata,
	// req_type[0]
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// read_data[7:0]
	output logic [M_DATA_W-1:0] m_tdata
);

	logic        en;
	item_t       item_in;
	logic        valid_s1;
	item_t       item_s1;
	logic [7:0]  century;
	logic        valid_s2;
	item_t       item_s2;
	logic [7:0]  century_s2;
	logic        is_read;
	sel_t        sel;
	logic        valid_s3;
	sel_t        sel_s3;
	logic [7:0]  code;
	logic        out_valid_q;
	logic [7:0]  out_data_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign item_in.req   = s_tuser;
	assign item_in.port  = s_tdata[15:0];
	assign item_in.wdata = s_tdata[23:16];
	assign item_in.sec   = s_tdata[29:24];
	assign item_in.min   = s_tdata[35:30];
	assign item_in.hour  = s_tdata[40:36];
	assign item_in.wday  = s_tdata[43:41];
	assign item_in.day   = s_tdata[48:44];
	assign item_in.month = s_tdata[52:49];
	assign item_in.year  = s_tdata[66:53];

	crp_year u_year (
		.year    (item_s1.year),
		.century (century)
	);

	crp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s2 && en),
		.item    (item_s2),
		.century (century_s2),
		.is_read (is_read),
		.sel     (sel)
	);

	crp_coder u_coder (
		.sel  (sel_s3),
		.code (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= s_tvalid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2 && is_read;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (s_tvalid) item_s1 <= item_in;
			item_s2    <= item_s1;
			century_s2 <= century;
			sel_s3     <= sel;
			out_data_q <= code;
		end
	end

endmodule
